FILE: hw/rtl/mvp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix-vector product package
// Shared constants and types for the top level, the front end and the back end.
// ----------------------------------------------------------------------------
package mvp_pkg;

   localparam int DEF_VECTOR_DEPTH = 1024;

   localparam int ColW    = 10;
   localparam int ValW    = 16;
   localparam int SumW    = 32;
   localparam int RowW    = 16;
   localparam int LenW    = 11;
   localparam int MaxLen  = 1024;

   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = QPtrW + 1;

   // action codes of an input word
   localparam logic ActVector = 1'b0;
   localparam logic ActMatrix = 1'b1;

   // register index, taken from paddr bit 2
   localparam logic RegRowLength = 1'b0;

   // one classified word waiting for the back end
   typedef struct packed {
      logic                   is_matrix;
      logic                   last;
      logic                   vec_zero;
      logic [ColW-1:0]        column;
      logic signed [ValW-1:0] value;
   } op_type;

   // queue status seen by the back end and the top level
   typedef struct packed {
      logic             full;
      logic             empty;
      logic             push;
      logic [QCntW-1:0] level;
   } q_stat_type;

endpackage

FILE: hw/rtl/matrix_vector_product_top.sv
`timescale 1ns / 1ps
// A row-ending matrix word goes from the queue to the RAM read and stage-1 registers,
// the product register and the result register. Throughput: one word per cycle, set by
// the pipelined multiply and accumulate and the one-write, one-read vector RAM; a stalled
// result freezes the back end and the 4-word queue then fills before req_stall rises.
// Reset clears the queue, pipeline, row sum and row counter and sets row_length
// to 1024; the vector store keeps whatever it held.
// ----------------------------------------------------------------------------
// Matrix-vector product top level
// Register port, front end with queue, back end with vector store.
// ----------------------------------------------------------------------------
module matrix_vector_product_top #(
   parameter int VECTOR_DEPTH = mvp_pkg::DEF_VECTOR_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [mvp_pkg::ColW-1:0]        req_column,
   input  logic signed [mvp_pkg::ValW-1:0] req_value,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [mvp_pkg::SumW-1:0] rsp_row_sum,
   output logic [mvp_pkg::RowW-1:0]        rsp_row_number,

   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [2:0]                      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic [mvp_pkg::LenW-1:0] row_length_ff, row_length_in;
   logic [mvp_pkg::LenW-1:0] eff_len;
   logic                     csr_wr;
   logic                     pop;
   mvp_pkg::op_type          head;
   mvp_pkg::q_stat_type      stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      row_length_in = row_length_ff;
      if (csr_wr && (csr_paddr[2] == mvp_pkg::RegRowLength)) begin
         row_length_in = csr_pwdata[mvp_pkg::LenW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= mvp_pkg::LenW'(mvp_pkg::MaxLen);
      end else begin
         row_length_ff <= row_length_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == mvp_pkg::RegRowLength) ? 32'(row_length_ff) : '0;

   // zero acts as one, anything past the maximum as the maximum
   always_comb begin
      if (row_length_ff == '0) begin
         eff_len = mvp_pkg::LenW'(1);
      end else if (row_length_ff > mvp_pkg::LenW'(mvp_pkg::MaxLen)) begin
         eff_len = mvp_pkg::LenW'(mvp_pkg::MaxLen);
      end else begin
         eff_len = row_length_ff;
      end
   end

   mvp_front #(
      .VECTOR_DEPTH (VECTOR_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_column (req_column),
      .req_value  (req_value),
      .eff_len    (eff_len),
      .pop        (pop),
      .head       (head),
      .stat       (stat)
   );

   mvp_back #(
      .VECTOR_DEPTH (VECTOR_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .stat           (stat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row_sum    (rsp_row_sum),
      .rsp_row_number (rsp_row_number)
   );

   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      stat.level <= mvp_pkg::QCntW'(mvp_pkg::QueueDepth))
      else $error("queue level beyond depth");

   a_queue_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && !stat.push) |=> (stat.level == $past(stat.level) - mvp_pkg::QCntW'(1)))
      else $error("queue level lost a pop");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      (eff_len != '0) && (eff_len <= mvp_pkg::LenW'(mvp_pkg::MaxLen)))
      else $error("effective row length out of range");

endmodule

FILE: hw/rtl/mvp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mvp_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                      rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/mvp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix-vector product front end
// Accepts input words, drops those with no effect, marks row ends and
// queues the rest for the back end.
// ----------------------------------------------------------------------------
module mvp_front #(
   parameter int VECTOR_DEPTH = mvp_pkg::DEF_VECTOR_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [mvp_pkg::ColW-1:0]       req_column,
   input  logic signed [mvp_pkg::ValW-1:0] req_value,
   input  logic [mvp_pkg::LenW-1:0]       eff_len,
   input  logic                           pop,
   output mvp_pkg::op_type                head,
   output mvp_pkg::q_stat_type            stat
);

   mvp_pkg::op_type                q_ff [mvp_pkg::QueueDepth];
   logic [mvp_pkg::QPtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [mvp_pkg::QPtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [mvp_pkg::QCntW-1:0]      count_ff, count_in;
   logic                           is_matrix;
   logic                           in_store;
   logic                           keep;
   logic                           push;
   logic                           full;
   mvp_pkg::op_type                op;

   assign full      = (count_ff == mvp_pkg::QCntW'(mvp_pkg::QueueDepth));
   assign req_stall = full;

   assign is_matrix = (req_action == mvp_pkg::ActMatrix);
   assign in_store  = (32'(req_column) < 32'(VECTOR_DEPTH));
   // matrix words past the row end and vector words past the store do nothing
   assign keep      = is_matrix ? (mvp_pkg::LenW'(req_column) < eff_len) : in_store;
   assign push      = req_valid && !req_stall && keep;

   always_comb begin
      op           = '0;
      op.is_matrix = is_matrix;
      op.last      = (mvp_pkg::LenW'(req_column) == (eff_len - mvp_pkg::LenW'(1)));
      op.vec_zero  = !in_store;
      op.column    = req_column;
      op.value     = req_value;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + mvp_pkg::QPtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + mvp_pkg::QPtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + mvp_pkg::QCntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - mvp_pkg::QCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= op;
      end
   end

   assign head       = q_ff[rd_ptr_ff];
   assign stat.full  = full;
   assign stat.empty = (count_ff == '0);
   assign stat.push  = push;
   assign stat.level = count_ff;

endmodule

FILE: hw/rtl/mvp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix-vector product back end
// Vector store, multiplier and row accumulator, with the result register.
// ----------------------------------------------------------------------------
module mvp_back #(
   parameter int VECTOR_DEPTH = mvp_pkg::DEF_VECTOR_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mvp_pkg::op_type                 head,
   input  mvp_pkg::q_stat_type             stat,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [mvp_pkg::SumW-1:0] rsp_row_sum,
   output logic [mvp_pkg::RowW-1:0]        rsp_row_number
);

   localparam int AddrW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

   logic                             adv;
   logic [AddrW+mvp_pkg::ColW-1:0]   col_wide;
   logic [AddrW-1:0]                 addr;
   logic [mvp_pkg::ValW-1:0]         rd_data;
   logic signed [mvp_pkg::ValW-1:0]  vec;

   logic                             s1_valid_ff;
   logic                             s1_last_ff;
   logic                             s1_zero_ff;
   logic signed [mvp_pkg::ValW-1:0]  s1_value_ff;

   logic                             s2_valid_ff;
   logic                             s2_last_ff;
   logic signed [mvp_pkg::SumW-1:0]  s2_prod_ff, s2_prod_in;

   logic [mvp_pkg::SumW-1:0]         sum_ff, sum_in;
   logic [mvp_pkg::SumW-1:0]         total;
   logic [mvp_pkg::RowW-1:0]         row_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [mvp_pkg::SumW-1:0]         rsp_sum_ff;
   logic [mvp_pkg::RowW-1:0]         rsp_row_ff;
   logic                             finish;

   // freeze the whole pipeline while a result waits behind a stall
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && !stat.empty;

   assign col_wide = {{AddrW{1'b0}}, head.column};
   assign addr     = col_wide[AddrW-1:0];

   mvp_ram #(
      .Width (mvp_pkg::ValW),
      .Depth (VECTOR_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (pop && !head.is_matrix),
      .wr_addr (addr),
      .wr_data (head.value),
      .rd_en   (pop && head.is_matrix),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   assign vec        = s1_zero_ff ? '0 : $signed(rd_data);
   assign s2_prod_in = s1_value_ff * vec;

   assign finish = adv && s2_valid_ff && s2_last_ff;
   assign total  = sum_ff + s2_prod_ff;

   always_comb begin
      sum_in = sum_ff;
      if (adv && s2_valid_ff) begin
         sum_in = s2_last_ff ? '0 : total;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         sum_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_valid_ff <= pop && head.is_matrix;
            s2_valid_ff <= s1_valid_ff;
         end
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            row_ff <= row_ff + mvp_pkg::RowW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_last_ff  <= head.last;
         s1_zero_ff  <= head.vec_zero;
         s1_value_ff <= head.value;
         s2_last_ff  <= s1_last_ff;
         s2_prod_ff  <= s2_prod_in;
      end
      if (finish) begin
         rsp_sum_ff <= total;
         rsp_row_ff <= row_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_sum    = $signed(rsp_sum_ff);
   assign rsp_row_number = rsp_row_ff;

endmodule
